// ===== design/tsft_pkg.sv =====
`timescale 1ns / 1ps

package tsft_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Result field widths.
   localparam int SLOT_FIELD_W  = 10;
   localparam int COUNT_FIELD_W = 11;
   localparam int TOTAL_W       = 33;

   // Direction codes.
   localparam logic [1:0] DIR_INBOUND  = 2'd1;
   localparam logic [1:0] DIR_OUTBOUND = 2'd2;

   // Bit positions in the TCP flags byte.
   localparam int FLAG_FIN_BIT = 0;
   localparam int FLAG_SYN_BIT = 1;
   localparam int FLAG_RST_BIT = 2;

   typedef enum logic [2:0] {
      ACT_IGNORED = 3'd0,
      ACT_ADDED   = 3'd1,
      ACT_UPDATED = 3'd2,
      ACT_DELETED = 3'd3,
      ACT_FIN     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // One session slot as it is kept in the table memory.
   typedef struct packed {
      logic        valid;
      logic [63:0] tuple;
      logic [31:0] tuple_high;
      logic [31:0] rx_packets;
      logic [31:0] tx_packets;
      logic [31:0] rx_bytes;
      logic [31:0] tx_bytes;
      logic [63:0] times;
   } slot_entry_type;

endpackage

// ===== design/tcp_session_flow_table.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  source/dest ip and port, direction, flags,
//                                           payload bytes, time
// rsp_      out        rsp_valid/rsp_stall  status, action, slot index, slot totals,
//                                           active session count
//
// Each item's slot is read from the table memory as the item is taken, then modified
// and written back in the lookup state; no new item is taken before that write-back.
// After reset the table memory is swept clear, one slot a cycle, over all TABLE_DEPTH
// slots (1024); no item is taken during the sweep.
// A waiting result sits in the output register; the next item is taken as soon as
// that register is empty or being emptied, and rsp_stall holds it otherwise.

module tcp_session_flow_table
   import tsft_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [31:0]              req_source_ip,
   input  logic [31:0]              req_dest_ip,
   input  logic [15:0]              req_source_port,
   input  logic [15:0]              req_dest_port,
   input  logic [1:0]               req_direction,
   input  logic [7:0]               req_tcp_flag_bits,
   input  logic [15:0]              req_payload_bytes,
   input  logic [31:0]              req_now_seconds,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_status,
   output logic [2:0]               rsp_action,
   output logic [SLOT_FIELD_W-1:0]  rsp_slot_index,
   output logic [TOTAL_W-1:0]       rsp_slot_packets,
   output logic [TOTAL_W-1:0]       rsp_slot_bytes,
   output logic [COUNT_FIELD_W-1:0] rsp_active_count
);

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Control state.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clear_idx_ff, clear_idx_in;
   logic [CNT_W-1:0] active_ff, active_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Item held during the lookup.
   logic [31:0]      source_ip_ff, dest_ip_ff;
   logic [15:0]      source_port_ff, dest_port_ff;
   logic [1:0]       direction_ff;
   logic [7:0]       flags_ff;
   logic [15:0]      payload_bytes_ff;
   logic [31:0]      now_ff;
   logic [IDX_W-1:0] slot_ff;

   // Result register.
   logic                     status_ff, status_in;
   action_type               action_ff, action_in;
   logic [SLOT_FIELD_W-1:0]  slot_index_ff, slot_index_in;
   logic [TOTAL_W-1:0]       packets_ff, packets_in;
   logic [TOTAL_W-1:0]       bytes_ff, bytes_in;
   logic [COUNT_FIELD_W-1:0] count_ff, count_in;

   logic             req_accept;
   logic [31:0]      hash;
   logic [IDX_W-1:0] slot_hash;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   slot_entry_type   rd_entry, new_entry;
   logic             lookup_wr;
   action_type       lookup_action;
   logic [CNT_W-1:0] active_next;
   logic             dir_ok;
   logic [31:0]      slot_wide, count_wide;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // Direction-dependent shift-XOR hash; the slot is its low bits.
   always_comb begin
      if (req_direction == DIR_INBOUND) begin
         hash = (req_source_ip >> 1) ^ 32'(req_source_port) ^ (req_dest_ip >> 2)
                ^ 32'(req_dest_port);
      end else begin
         hash = (req_dest_ip >> 1) ^ 32'(req_dest_port) ^ (req_source_ip >> 2)
                ^ 32'(req_source_port);
      end
      slot_hash = hash[IDX_W-1:0];
   end

   tsft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (slot_hash),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = slot_entry_type'(ram_rd_data);

   // Slot update for the item under lookup.
   always_comb begin
      dir_ok        = (direction_ff == DIR_INBOUND) || (direction_ff == DIR_OUTBOUND);
      new_entry     = rd_entry;
      lookup_wr     = 1'b0;
      lookup_action = ACT_IGNORED;
      active_next   = active_ff;
      if (dir_ok) begin
         if (!rd_entry.valid) begin
            if ((direction_ff == DIR_INBOUND) && flags_ff[FLAG_SYN_BIT]) begin
               new_entry.valid      = 1'b1;
               new_entry.tuple      = {source_ip_ff, dest_ip_ff};
               new_entry.tuple_high = {source_port_ff, dest_port_ff};
               new_entry.rx_packets = 32'd1;
               new_entry.tx_packets = 32'd0;
               new_entry.rx_bytes   = 32'(payload_bytes_ff);
               new_entry.tx_bytes   = 32'd0;
               new_entry.times      = {now_ff, now_ff};
               lookup_wr            = 1'b1;
               lookup_action        = ACT_ADDED;
               active_next          = active_ff + CNT_W'(1);
            end
         end else if (flags_ff[FLAG_RST_BIT]) begin
            new_entry     = '0;
            lookup_wr     = 1'b1;
            lookup_action = ACT_DELETED;
            active_next   = (active_ff == '0) ? '0 : active_ff - CNT_W'(1);
         end else if (flags_ff[FLAG_FIN_BIT]) begin
            lookup_action = ACT_FIN;
         end else begin
            if (direction_ff == DIR_INBOUND) begin
               new_entry.rx_packets = rd_entry.rx_packets + 32'd1;
               new_entry.rx_bytes   = rd_entry.rx_bytes + 32'(payload_bytes_ff);
            end else begin
               new_entry.tx_packets = rd_entry.tx_packets + 32'd1;
               new_entry.tx_bytes   = rd_entry.tx_bytes + 32'(payload_bytes_ff);
            end
            new_entry.times[31:0] = now_ff;
            lookup_wr             = 1'b1;
            lookup_action         = ACT_UPDATED;
         end
      end
      slot_wide  = 32'(slot_ff);
      count_wide = 32'(active_next);
   end

   // Next state, memory write and result register.
   always_comb begin
      state_in      = state_ff;
      clear_idx_in  = clear_idx_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      status_in     = status_ff;
      action_in     = action_ff;
      slot_index_in = slot_index_ff;
      packets_in    = packets_ff;
      bytes_in      = bytes_ff;
      count_in      = count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = ENTRY_W'(new_entry);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = clear_idx_ff;
            ram_wr_data  = '0;
            clear_idx_in = clear_idx_ff + IDX_W'(1);
            if (clear_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ram_wr_en     = lookup_wr;
            active_in     = active_next;
            rsp_valid_in  = 1'b1;
            status_in     = !dir_ok;
            action_in     = lookup_action;
            slot_index_in = dir_ok ? slot_wide[SLOT_FIELD_W-1:0] : '0;
            packets_in    = dir_ok ? ({1'b0, new_entry.rx_packets}
                                     + {1'b0, new_entry.tx_packets}) : '0;
            bytes_in      = dir_ok ? ({1'b0, new_entry.rx_bytes}
                                     + {1'b0, new_entry.tx_bytes}) : '0;
            count_in      = count_wide[COUNT_FIELD_W-1:0];
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         source_ip_ff     <= req_source_ip;
         dest_ip_ff       <= req_dest_ip;
         source_port_ff   <= req_source_port;
         dest_port_ff     <= req_dest_port;
         direction_ff     <= req_direction;
         flags_ff         <= req_tcp_flag_bits;
         payload_bytes_ff <= req_payload_bytes;
         now_ff           <= req_now_seconds;
         slot_ff          <= slot_hash;
      end
      status_ff     <= status_in;
      action_ff     <= action_in;
      slot_index_ff <= slot_index_in;
      packets_ff    <= packets_in;
      bytes_ff      <= bytes_in;
      count_ff      <= count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_action       = action_ff;
   assign rsp_slot_index   = slot_index_ff;
   assign rsp_slot_packets = packets_ff;
   assign rsp_slot_bytes   = bytes_ff;
   assign rsp_active_count = count_ff;

`ifndef SYNTHESIS
   // No item is taken while the table is being swept clear.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("item accepted during table clear");

   // An accepted item is looked up in the following cycle.
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted item not looked up");

   // The result register is empty whenever a lookup finishes.
   a_rsp_free_in_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // A new result appears only right after a lookup.
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("result without lookup");

   // The session count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= CNT_W'(TABLE_DEPTH))
      else $error("active session count out of range");
`endif

endmodule

// ===== design/tsft_ram.sv =====
`timescale 1ns / 1ps

module tsft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/tcp_session_flow_table_tb.sv =====
`timescale 1ns / 1ps

module tcp_session_flow_table_tb;
   import tsft_pkg::*;

   localparam int RANDOM_ITEMS   = 1830;
   localparam int CALM_ITEMS     = 150;
   localparam int FLOW_COUNT     = 48;
   localparam int REPORT_LIMIT   = 10;
   // The limit has to cover the clearing sweep after reset, which visits every table
   // slot, and one item's time in the block plus an input gap and result stalls.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 16;

   localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
   localparam logic [1:0] DIR_RESERVED = 2'd3;

   localparam logic [7:0] NO_FLAGS  = 8'h00;
   localparam logic [7:0] FIN_ONLY  = 8'(1 << FLAG_FIN_BIT);
   localparam logic [7:0] SYN_ONLY  = 8'(1 << FLAG_SYN_BIT);
   localparam logic [7:0] RST_ONLY  = 8'(1 << FLAG_RST_BIT);
   localparam logic [7:0] RST_FIN   = RST_ONLY | FIN_ONLY;
   localparam logic [7:0] ALL_FLAGS = 8'hFF;

   typedef struct packed {
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [1:0]  direction;
      logic [7:0]  flags;
      logic [15:0] payload;
      logic [31:0] seconds;
   } header_type;

   typedef struct packed {
      logic                     status;
      action_type               action;
      logic [SLOT_FIELD_W-1:0]  slot;
      logic [TOTAL_W-1:0]       packets;
      logic [TOTAL_W-1:0]       bytes;
      logic [COUNT_FIELD_W-1:0] active;
   } verdict_type;

   typedef struct packed {
      header_type  hdr;
      logic        typed;
      verdict_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   logic [31:0]              req_source_ip     = '0;
   logic [31:0]              req_dest_ip       = '0;
   logic [15:0]              req_source_port   = '0;
   logic [15:0]              req_dest_port     = '0;
   logic [1:0]               req_direction     = '0;
   logic [7:0]               req_tcp_flag_bits = '0;
   logic [15:0]              req_payload_bytes = '0;
   logic [31:0]              req_now_seconds   = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_status;
   logic [2:0]               rsp_action;
   logic [SLOT_FIELD_W-1:0]  rsp_slot_index;
   logic [TOTAL_W-1:0]       rsp_slot_packets;
   logic [TOTAL_W-1:0]       rsp_slot_bytes;
   logic [COUNT_FIELD_W-1:0] rsp_active_count;

   tcp_session_flow_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_source_ip     (req_source_ip),
      .req_dest_ip       (req_dest_ip),
      .req_source_port   (req_source_port),
      .req_dest_port     (req_dest_port),
      .req_direction     (req_direction),
      .req_tcp_flag_bits (req_tcp_flag_bits),
      .req_payload_bytes (req_payload_bytes),
      .req_now_seconds   (req_now_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_action        (rsp_action),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_slot_packets  (rsp_slot_packets),
      .rsp_slot_bytes    (rsp_slot_bytes),
      .rsp_active_count  (rsp_active_count)
   );

   always #5 clock = ~clock;

   // Predicted session table. Stored tuples and times never reach a result,
   // so only the counters and the occupancy are kept.
   bit          slot_live     [TABLE_DEPTH];
   bit   [31:0] slot_rx_pkts  [TABLE_DEPTH];
   bit   [31:0] slot_tx_pkts  [TABLE_DEPTH];
   bit   [31:0] slot_rx_bytes [TABLE_DEPTH];
   bit   [31:0] slot_tx_bytes [TABLE_DEPTH];
   int          live_sessions = 0;

   verdict_type      expected_verdicts [$];
   directed_row_type directed_rows [$];

   // Flow pool for the session traffic.
   logic [31:0] flow_sip  [FLOW_COUNT];
   logic [31:0] flow_dip  [FLOW_COUNT];
   logic [15:0] flow_sp   [FLOW_COUNT];
   logic [15:0] flow_dp   [FLOW_COUNT];
   bit          flow_open [FLOW_COUNT];
   logic [31:0] wall_seconds = 32'hFFFF_FF00;

   int  mismatch_count  = 0;
   int  headers_sent    = 0;
   int  results_checked = 0;
   int  opened_count    = 0;
   int  updated_count   = 0;
   int  fin_count       = 0;
   int  removed_count   = 0;
   int  ignored_count   = 0;
   int  peak_active     = 0;
   int  quiet_cycles    = 0;
   int  stall_left      = 0;
   int  stall_cycle     = 0;
   logic calm_tail      = 1'b0;

   // Works out the result of one header and updates the predicted table.
   function automatic verdict_type predict_session(input header_type h);
      verdict_type v;
      logic [31:0] hash;
      int          s;
      v = '0;
      v.action = ACT_IGNORED;
      if (h.direction != DIR_INBOUND && h.direction != DIR_OUTBOUND) begin
         v.status = 1'b1;
         v.active = COUNT_FIELD_W'(live_sessions);
         return v;
      end
      if (h.direction == DIR_INBOUND) begin
         hash = (h.source_ip >> 1) ^ {16'd0, h.source_port}
              ^ (h.dest_ip >> 2) ^ {16'd0, h.dest_port};
      end else begin
         hash = (h.dest_ip >> 1) ^ {16'd0, h.dest_port}
              ^ (h.source_ip >> 2) ^ {16'd0, h.source_port};
      end
      s = int'(hash % TABLE_DEPTH);

      if (!slot_live[s]) begin
         // Only an inbound SYN opens an empty slot.
         if (h.direction == DIR_INBOUND && h.flags[FLAG_SYN_BIT]) begin
            slot_live[s]     = 1'b1;
            slot_rx_pkts[s]  = 32'd1;
            slot_tx_pkts[s]  = 32'd0;
            slot_rx_bytes[s] = {16'd0, h.payload};
            slot_tx_bytes[s] = 32'd0;
            live_sessions++;
            v.action = ACT_ADDED;
         end
      end else if (h.flags[FLAG_RST_BIT]) begin
         // Reset wins over FIN and clears the slot.
         slot_live[s]     = 1'b0;
         slot_rx_pkts[s]  = 32'd0;
         slot_tx_pkts[s]  = 32'd0;
         slot_rx_bytes[s] = 32'd0;
         slot_tx_bytes[s] = 32'd0;
         if (live_sessions > 0) live_sessions--;
         v.action = ACT_DELETED;
      end else if (h.flags[FLAG_FIN_BIT]) begin
         v.action = ACT_FIN;
      end else if (h.direction == DIR_INBOUND) begin
         slot_rx_pkts[s]  = slot_rx_pkts[s] + 32'd1;
         slot_rx_bytes[s] = slot_rx_bytes[s] + {16'd0, h.payload};
         v.action = ACT_UPDATED;
      end else begin
         slot_tx_pkts[s]  = slot_tx_pkts[s] + 32'd1;
         slot_tx_bytes[s] = slot_tx_bytes[s] + {16'd0, h.payload};
         v.action = ACT_UPDATED;
      end

      v.slot    = SLOT_FIELD_W'(s);
      v.packets = {1'b0, slot_rx_pkts[s]} + {1'b0, slot_tx_pkts[s]};
      v.bytes   = {1'b0, slot_rx_bytes[s]} + {1'b0, slot_tx_bytes[s]};
      v.active  = COUNT_FIELD_W'(live_sessions);
      return v;
   endfunction

   // Presents one header, waits for it to be taken and queues its result.
   // A typed row supplies its own expected result; the table is still updated.
   task automatic offer_header(input header_type h, input bit gaps_ok, input logic typed,
                               input verdict_type want);
      verdict_type predicted;
      if (gaps_ok && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_source_ip     <= h.source_ip;
      req_dest_ip       <= h.dest_ip;
      req_source_port   <= h.source_port;
      req_dest_port     <= h.dest_port;
      req_direction     <= h.direction;
      req_tcp_flag_bits <= h.flags;
      req_payload_bytes <= h.payload;
      req_now_seconds   <= h.seconds;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_session(h);
      expected_verdicts.push_back(typed ? want : predicted);
      headers_sent++;
   endtask

   task automatic renew_flow(input int f);
      flow_sip[f]  = $urandom;
      flow_dip[f]  = $urandom;
      flow_sp[f]   = 16'($urandom);
      flow_dp[f]   = 16'($urandom);
      flow_open[f] = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch on %s of result %0d: expected %0h, got %0h",
                     name, results_checked, want, got);
      end
   endtask

   // Result checker: each item taken is compared with the oldest expectation.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Result item with nothing expected: action %0d, slot %0d",
                        rsp_action, rsp_slot_index);
         end else begin
            want = expected_verdicts.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("action", 64'(want.action), 64'(rsp_action));
            check_field("slot_index", 64'(want.slot), 64'(rsp_slot_index));
            check_field("slot_packets", 64'(want.packets), 64'(rsp_slot_packets));
            check_field("slot_bytes", 64'(want.bytes), 64'(rsp_slot_bytes));
            check_field("active_count", 64'(want.active), 64'(rsp_active_count));
            results_checked++;
            case (want.action)
               ACT_ADDED:   opened_count++;
               ACT_UPDATED: updated_count++;
               ACT_FIN:     fin_count++;
               ACT_DELETED: removed_count++;
               default:     ignored_count++;
            endcase
            if (int'(want.active) > peak_active) peak_active = int'(want.active);
         end
      end
   end

   // Result side back-pressure: random bursts of stalled cycles, with quiet windows,
   // and no new burst once the calm tail of the run begins.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm_tail && (stall_cycle % 512) < 400 && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
      stall_cycle++;
   end

   // Watchdog: ends the run when no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_verdicts.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      header_type h;
      int         f;
      int         pick;
      bit         gaps_ok;

      // Directed rows. Every flow here uses the all-zero or all-ones tuple,
      // which both hash to slot 0, or short hand-made flows.
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_UNKNOWN, NO_FLAGS,
         16'd0, 32'd1}, 1'b1, '{1'b1, ACT_IGNORED, 10'd0, 33'd0, 33'd0, 11'd0}});
      directed_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
         DIR_RESERVED, ALL_FLAGS, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
         '{1'b1, ACT_IGNORED, 10'd0, 33'd0, 33'd0, 11'd0}});
      // Empty slot: plain inbound, outbound SYN and inbound RST are all ignored.
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_INBOUND, NO_FLAGS,
         16'd100, 32'd1}, 1'b1, '{1'b0, ACT_IGNORED, 10'd0, 33'd0, 33'd0, 11'd0}});
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_OUTBOUND, SYN_ONLY,
         16'd100, 32'd2}, 1'b1, '{1'b0, ACT_IGNORED, 10'd0, 33'd0, 33'd0, 11'd0}});
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_INBOUND, RST_ONLY,
         16'd0, 32'd3}, 1'b1, '{1'b0, ACT_IGNORED, 10'd0, 33'd0, 33'd0, 11'd0}});
      // Open slot 0, then update, FIN, SYN as update, and RST with FIN.
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_INBOUND, SYN_ONLY,
         16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{1'b0, ACT_ADDED, 10'd0, 33'd1, 33'd65535, 11'd1}});
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_OUTBOUND, NO_FLAGS,
         16'hFFFF, 32'd0}, 1'b1, '{1'b0, ACT_UPDATED, 10'd0, 33'd2, 33'd131070, 11'd1}});
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_INBOUND, FIN_ONLY,
         16'hFFFF, 32'd5}, 1'b1, '{1'b0, ACT_FIN, 10'd0, 33'd2, 33'd131070, 11'd1}});
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_INBOUND, SYN_ONLY,
         16'd1, 32'd6}, 1'b1, '{1'b0, ACT_UPDATED, 10'd0, 33'd3, 33'd131071, 11'd1}});
      directed_rows.push_back('{'{32'h0, 32'h0, 16'h0, 16'h0, DIR_OUTBOUND, RST_FIN,
         16'd0, 32'd7}, 1'b1, '{1'b0, ACT_DELETED, 10'd0, 33'd0, 33'd0, 11'd0}});
      // All-ones tuple with every flag: opens slot 0, then the same removes it.
      directed_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
         DIR_INBOUND, ALL_FLAGS, 16'd0, 32'd0}, 1'b1,
         '{1'b0, ACT_ADDED, 10'd0, 33'd1, 33'd0, 11'd1}});
      directed_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
         DIR_INBOUND, ALL_FLAGS, 16'hFFFF, 32'd8}, 1'b1,
         '{1'b0, ACT_DELETED, 10'd0, 33'd0, 33'd0, 11'd0}});
      // Hand-made flows and their replies, checked by prediction.
      directed_rows.push_back('{'{32'hC0A8_0001, 32'h0A00_0002, 16'd443, 16'd51000,
         DIR_INBOUND, 8'h12, 16'd0, 32'd1}, 1'b0, '0});
      directed_rows.push_back('{'{32'h0A00_0002, 32'hC0A8_0001, 16'd51000, 16'd443,
         DIR_OUTBOUND, 8'h10, 16'd1460, 32'd2}, 1'b0, '0});
      directed_rows.push_back('{'{32'hC0A8_0001, 32'h0A00_0002, 16'd443, 16'd51000,
         DIR_INBOUND, 8'h18, 16'hFFFF, 32'd3}, 1'b0, '0});
      directed_rows.push_back('{'{32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001,
         DIR_INBOUND, 8'hE2, 16'h8000, 32'h8000_0000}, 1'b0, '0});
      directed_rows.push_back('{'{32'h0000_0001, 32'h8000_0000, 16'h0001, 16'h8000,
         DIR_OUTBOUND, 8'h08, 16'h7FFF, 32'h8000_0001}, 1'b0, '0});
      directed_rows.push_back('{'{32'hC0A8_0001, 32'h0A00_0002, 16'd443, 16'd51000,
         DIR_INBOUND, 8'h11, 16'd0, 32'd4}, 1'b0, '0});
      directed_rows.push_back('{'{32'h0000_0001, 32'h8000_0000, 16'h0001, 16'h8000,
         DIR_OUTBOUND, RST_ONLY, 16'd0, 32'd5}, 1'b0, '0});
      directed_rows.push_back('{'{32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF,
         DIR_OUTBOUND, NO_FLAGS, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '0});

      for (f = 0; f < FLOW_COUNT; f++) renew_flow(f);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_header(directed_rows[i].hdr, 1'b1, directed_rows[i].typed,
                      directed_rows[i].want);

      // Random part: mostly interleaved sessions with random content, the rest
      // noise and broken sequences.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_ok = (n < RANDOM_ITEMS - CALM_ITEMS) && ((n % 300) < 230);
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm_tail <= 1'b1;
         pick = $urandom_range(0, 99);
         f = $urandom_range(0, FLOW_COUNT - 1);
         wall_seconds = wall_seconds + 32'($urandom_range(0, 5));

         case ($urandom_range(0, 15))
            0:       h.payload = 16'h0000;
            1:       h.payload = 16'hFFFF;
            default: h.payload = 16'($urandom);
         endcase
         h.seconds = wall_seconds;

         if (pick < 12) begin
            // Noise: any header at all, unknown directions included.
            h.source_ip   = $urandom;
            h.dest_ip     = $urandom;
            h.source_port = 16'($urandom);
            h.dest_port   = 16'($urandom);
            h.direction   = 2'($urandom);
            h.flags       = 8'($urandom);
            h.seconds     = $urandom;
         end else begin
            h.flags     = 8'($urandom) & 8'hF8;
            h.direction = $urandom_range(0, 1) ? DIR_INBOUND : DIR_OUTBOUND;
            if (!flow_open[f]) begin
               if ($urandom_range(0, 9) != 0) begin
                  h.direction = DIR_INBOUND;
                  h.flags[FLAG_SYN_BIT] = 1'b1;
                  flow_open[f] = 1'b1;
               end else begin
                  h.flags = 8'($urandom);
               end
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 72) begin
                  h.flags[FLAG_SYN_BIT] = ($urandom_range(0, 9) == 0);
               end else if (pick < 82) begin
                  h.flags[FLAG_FIN_BIT] = 1'b1;
                  h.flags[FLAG_SYN_BIT] = 1'($urandom);
               end else if (pick < 94) begin
                  h.flags[FLAG_RST_BIT] = 1'b1;
                  h.flags[FLAG_FIN_BIT] = 1'($urandom);
                  flow_open[f] = 1'b0;
               end
            end
            // Replies travel with the tuple reversed and land on the same slot.
            if (h.direction == DIR_INBOUND) begin
               h.source_ip   = flow_sip[f];
               h.dest_ip     = flow_dip[f];
               h.source_port = flow_sp[f];
               h.dest_port   = flow_dp[f];
            end else begin
               h.source_ip   = flow_dip[f];
               h.dest_ip     = flow_sip[f];
               h.source_port = flow_dp[f];
               h.dest_port   = flow_sp[f];
            end
            // Some flows end with a reset, others are simply abandoned so
            // that the table fills up over the run.
            if (!flow_open[f] && h.flags[FLAG_RST_BIT] && $urandom_range(0, 1) == 0)
               renew_flow(f);
            else if (pick >= 94 && flow_open[f])
               renew_flow(f);
         end
         offer_header(h, gaps_ok, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d headers and %0d checked results: %0d opened, %0d updated,",
               headers_sent, results_checked, opened_count, updated_count);
      $display("%0d FIN, %0d removed, %0d ignored or rejected; at most %0d sessions live.",
               fin_count, removed_count, ignored_count, peak_active);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== tcp_session_flow_table.f =====
design/tsft_pkg.sv
design/tsft_ram.sv
design/tcp_session_flow_table.sv
test/tcp_session_flow_table_tb.sv
